// ===== design/fcfe_pkg.sv =====
package fcfe_pkg;

  localparam int ENTRIES     = 64;
  localparam int KEY_BITS    = 24;
  localparam int HANDLE_BITS = 32;

  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);
  localparam int CAP_BITS   = 7;
  localparam int COUNT_BITS = 7;
  localparam int WIDE_BITS  = ((CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS) + 1;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  function automatic logic [KEY_BITS-1:0] key_dist(input logic [KEY_BITS-1:0] a,
                                                   input logic [KEY_BITS-1:0] b);
    key_dist = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [WIDE_BITS-1:0] cap_limit(input logic [CAP_BITS-1:0] c);
    logic [WIDE_BITS-1:0] cw;
    cw = WIDE_BITS'(c);
    if (c == '0) begin
      cap_limit = WIDE_BITS'(1);
    end else if (cw > WIDE_BITS'(ENTRIES)) begin
      cap_limit = WIDE_BITS'(ENTRIES);
    end else begin
      cap_limit = cw;
    end
  endfunction

endpackage

// ===== design/fcfe_ram.sv =====
module fcfe_ram #(
  parameter int DATA_BITS = 8,
  parameter int ADDR_BITS = 6,
  parameter int DEPTH     = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/frame_cache_farthest_eviction.sv =====
// Lookup and range invalidate each make one read sweep through the entry memory; clear
// makes no sweep. Insert makes one key sweep plus one farthest-entry sweep each time
// the entries would exceed the capacity; one item is in flight at a time.
// Reset (synchronous) empties the table, zeroes the count and sets capacity to 64.
module frame_cache_farthest_eviction import fcfe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_BITS-1:0]    capacity,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             operation,
  input  logic [KEY_BITS-1:0]    frame_key,
  input  logic [HANDLE_BITS-1:0] image_handle,
  input  logic [KEY_BITS-1:0]    playhead,
  input  logic [KEY_BITS-1:0]    range_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   hit,
  output logic [HANDLE_BITS-1:0] handle_out,
  output logic [COUNT_BITS-1:0]  entry_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PASS   = 3'd2;
  localparam logic [2:0] S_EVCHK  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [1:0] M_FIND  = 2'd0;
  localparam logic [1:0] M_RANGE = 2'd1;
  localparam logic [1:0] M_FAR   = 2'd2;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

  logic [2:0]             state;
  logic [1:0]             mode;
  logic [CAP_BITS-1:0]    cap_cfg;
  logic [ENTRIES-1:0]     valid;
  logic [CNT_BITS-1:0]    count;

  logic [1:0]             op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [KEY_BITS-1:0]    cur_q;
  logic [KEY_BITS-1:0]    lo_q;
  logic [KEY_BITS-1:0]    hi_q;

  logic [IDX_BITS-1:0]    iss;
  logic                   iss_on;
  logic                   rd_v;
  logic [IDX_BITS-1:0]    rd_idx;
  logic                   rd_last;
  logic                   s2_v;
  logic [IDX_BITS-1:0]    s2_idx;
  logic                   s2_last;
  logic [KEY_BITS-1:0]    s2_key;
  logic [HANDLE_BITS-1:0] s2_handle;
  logic [KEY_BITS-1:0]    s2_dist;

  logic                   found;
  logic [IDX_BITS-1:0]    found_idx;
  logic [HANDLE_BITS-1:0] found_handle;
  logic                   free_found;
  logic [IDX_BITS-1:0]    free_idx;
  logic                   pending;
  logic [KEY_BITS-1:0]    pend_dist;
  logic                   have;
  logic                   best_pend;
  logic [IDX_BITS-1:0]    best_idx;
  logic [KEY_BITS-1:0]    best_key;
  logic [KEY_BITS-1:0]    best_dist;

  logic                   res_hit;
  logic [HANDLE_BITS-1:0] res_handle;

  logic                   accept;
  logic                   load_out;
  logic                   s2_ent_v;
  logic                   better;
  logic                   over;
  logic                   ram_we;
  logic [IDX_BITS-1:0]    ram_waddr;
  logic                   ram_re;
  logic [ENTRY_BITS-1:0]  ram_rdata;
  entry_t                 rd_ent;
  entry_t                 wr_ent;
  logic [WIDE_BITS-1:0]   cnt_plus;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign load_out  = (state == S_FINISH) && (!out_valid || !out_stall);

  assign s2_ent_v = valid[s2_idx];
  assign better   = !have || (s2_dist > best_dist) ||
                    ((s2_dist == best_dist) && (s2_key < best_key));
  assign cnt_plus = WIDE_BITS'(count) + WIDE_BITS'(pending);
  assign over     = cnt_plus > cap_limit(cap_cfg);

  assign rd_ent       = entry_t'(ram_rdata);
  assign wr_ent.key    = key_q;
  assign wr_ent.handle = handle_q;
  assign ram_re       = (state == S_SCAN) && iss_on;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx;
    case (state)
      S_PASS: begin
        if ((mode == M_FIND) && (op_q == OP_INSERT)) begin
          ram_we    = found || free_found;
          ram_waddr = found ? found_idx : free_idx;
        end
      end
      S_EVCHK: begin
        ram_we = !over && pending;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fcfe_ram #(
    .DATA_BITS(ENTRY_BITS),
    .ADDR_BITS(IDX_BITS),
    .DEPTH    (ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_ent),
    .re   (ram_re),
    .raddr(iss),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_idx    <= iss;
    rd_last   <= (iss == LAST_IDX);
    s2_idx    <= rd_idx;
    s2_last   <= rd_last;
    s2_key    <= rd_ent.key;
    s2_handle <= rd_ent.handle;
    s2_dist   <= key_dist(rd_ent.key, cur_q);
    if (accept) begin
      op_q     <= operation;
      key_q    <= frame_key;
      handle_q <= image_handle;
      cur_q    <= playhead;
      if (frame_key > range_end) begin
        lo_q <= range_end;
        hi_q <= frame_key;
      end else begin
        lo_q <= frame_key;
        hi_q <= range_end;
      end
    end
    if (load_out) begin
      hit         <= res_hit;
      handle_out  <= res_handle;
      entry_count <= COUNT_BITS'(WIDE_BITS'(count));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_FIND;
      cap_cfg   <= CAP_RESET;
      valid     <= '0;
      count     <= '0;
      iss_on    <= 1'b0;
      rd_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_cfg <= capacity;
      end
      rd_v <= ram_re;
      s2_v <= rd_v;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_hit    <= 1'b0;
            res_handle <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            pending    <= 1'b0;
            iss        <= '0;
            if (operation == OP_CLEAR) begin
              valid <= '0;
              count <= '0;
              state <= S_FINISH;
            end else begin
              mode   <= (operation == OP_RANGE) ? M_RANGE : M_FIND;
              iss_on <= 1'b1;
              state  <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (iss_on) begin
            iss <= iss + IDX_BITS'(1);
            if (iss == LAST_IDX) begin
              iss_on <= 1'b0;
            end
          end
          if (s2_v) begin
            case (mode)
              M_FIND: begin
                if (s2_ent_v && (s2_key == key_q) && !found) begin
                  found        <= 1'b1;
                  found_idx    <= s2_idx;
                  found_handle <= s2_handle;
                end
                if (!s2_ent_v && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= s2_idx;
                end
              end
              M_RANGE: begin
                if (s2_ent_v && (s2_key >= lo_q) && (s2_key <= hi_q)) begin
                  valid[s2_idx] <= 1'b0;
                  count         <= count - CNT_BITS'(1);
                end
              end
              M_FAR: begin
                if (s2_ent_v && better) begin
                  have      <= 1'b1;
                  best_pend <= 1'b0;
                  best_idx  <= s2_idx;
                  best_key  <= s2_key;
                  best_dist <= s2_dist;
                end
              end
              default: begin
                have <= have;
              end
            endcase
            if (s2_last) begin
              state <= S_PASS;
            end
          end
        end

        S_PASS: begin
          case (mode)
            M_FIND: begin
              if (op_q == OP_LOOKUP) begin
                res_hit    <= found;
                res_handle <= found ? found_handle : '0;
                state      <= S_FINISH;
              end else begin
                if (!found) begin
                  if (free_found) begin
                    valid[free_idx] <= 1'b1;
                    count           <= count + CNT_BITS'(1);
                  end else begin
                    pending <= 1'b1;
                  end
                end
                pend_dist <= key_dist(key_q, cur_q);
                state     <= S_EVCHK;
              end
            end
            M_FAR: begin
              if (have) begin
                if (best_pend) begin
                  pending <= 1'b0;
                end else begin
                  valid[best_idx] <= 1'b0;
                  count           <= count - CNT_BITS'(1);
                  free_idx        <= best_idx;
                end
              end
              state <= S_EVCHK;
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end

        S_EVCHK: begin
          if (over) begin
            have      <= pending;
            best_pend <= pending;
            best_key  <= key_q;
            best_dist <= pend_dist;
            mode      <= M_FAR;
            iss       <= '0;
            iss_on    <= 1'b1;
            state     <= S_SCAN;
          end else begin
            if (pending) begin
              valid[free_idx] <= 1'b1;
              count           <= count + CNT_BITS'(1);
              pending         <= 1'b0;
            end
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
